// ===== hdl/ip8_pkg.sv =====
// shared types and constants for the intra 8x8 predictor
// no dependencies
package ip8_pkg;

	localparam int NB_N     = 33;
	localparam int EDGE_N   = 35;
	localparam int EDGE_MID = 17;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PREDICT = 1'b1;

	localparam logic [3:0] MODE_V      = 4'd0;
	localparam logic [3:0] MODE_H      = 4'd1;
	localparam logic [3:0] MODE_DC     = 4'd2;
	localparam logic [3:0] MODE_DDL    = 4'd3;
	localparam logic [3:0] MODE_DDR    = 4'd4;
	localparam logic [3:0] MODE_DCL    = 4'd5;
	localparam logic [3:0] MODE_DCT    = 4'd6;
	localparam logic [3:0] MODE_FLAT   = 4'd7;
	localparam logic [3:0] MODE_PLANE  = 4'd8;

	localparam logic [7:0] PIX_MID = 8'd128;

	typedef logic [7:0] pix_t;

	// one queued predict: flags plus a snapshot of the neighbor pixels
	typedef struct packed {
		logic [3:0]             mode;
		logic                   chroma;
		logic                   hl;
		logic                   ht;
		logic                   htl;
		logic                   htr;
		logic                   hdl;
		logic [NB_N-1:0][7:0]   nb;
	} pred_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} qctl_t;

endpackage

// ===== hdl/intra_8x8_predictor_core.sv =====
// channel | dir | tdata (low bit up)                                   | tuser    | tlast
// s_      | in  | sample_index, sample_value, mode, is_chroma, have_left,| cmd      | -
//         |     | have_top, have_topleft, have_topright, have_downleft   |          |
// m_      | out | row_index, row_pixels, zero pad                        | bad_mode | last_row
// a load stores one neighbor pixel; a predict runs the edge and plane setup states
// in the back end and then sends 8 row words, one per cycle when m_tready stays high
// the two-entry predict queue lets loads and predicts keep arriving while rows go out
// s_tready drops only when the queue is full; a stalled row holds in the output register
// arst_n clears the queue and the sequencer; pixel stores hold no reset value
// top level of the intra 8x8 predictor; depends on ip8_pkg, ip8_front, ip8_back
module intra_8x8_predictor_core import ip8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample_index, sample_value, mode, is_chroma,
	                               // have_left, have_top, have_topleft,
	                               // have_topright, have_downleft
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // row_index, row_pixels, zero pad
	output logic        m_tuser,   // bad_mode
	output logic        m_tlast
);

	pred_t head;
	logic  head_valid;
	qctl_t qctl;

	ip8_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.head, .qin(qctl), .head_valid
	);

	ip8_back u_back (
		.clk, .arst_n, .head, .head_valid, .qout(qctl),
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

endmodule

// ===== hdl/ip8_front.sv =====
// front end: takes input words, keeps the neighbor pixels, queues predicts
// depends on ip8_pkg
module ip8_front import ip8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	output pred_t       head,
	input  qctl_t       qin,
	output logic        head_valid
);

	logic [NB_N-1:0][7:0] nb_q;
	pred_t                fifo_q [2];
	logic                 wr_q, rd_q;
	logic [1:0]           cnt_q;
	logic                 acc, push, pop;
	logic [5:0]           idx;
	pred_t                ent;

	assign s_tready   = (cnt_q != 2'd2);
	assign acc        = s_tvalid & s_tready;
	assign push       = acc & (s_tuser == CMD_PREDICT);
	assign pop        = qin.pop & (cnt_q != 2'd0);
	assign idx        = s_tdata[5:0];
	assign head       = fifo_q[rd_q];
	assign head_valid = (cnt_q != 2'd0);

	always_comb begin
		ent.mode   = s_tdata[17:14];
		ent.chroma = s_tdata[18];
		ent.hl     = s_tdata[19];
		ent.ht     = s_tdata[20];
		ent.htl    = s_tdata[21];
		ent.htr    = s_tdata[22];
		ent.hdl    = s_tdata[23];
		ent.nb     = nb_q;
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (acc && s_tuser == CMD_LOAD && idx < 6'(NB_N)) begin
			nb_q[idx] <= s_tdata[13:6];
		end
		if (push) begin
			fifo_q[wr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/ip8_back.sv =====
// back end: edge build and smoothing, plane setup, row generation
// depends on ip8_pkg
module ip8_back import ip8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pred_t       head,
	input  logic        head_valid,
	output qctl_t       qout,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EDGE  = 2'd1;
	localparam logic [1:0] ST_PLANE = 2'd2;
	localparam logic [1:0] ST_ROWS  = 2'd3;

	logic [1:0]              state_q;
	logic [EDGE_N-1:0][7:0]  edge_q;
	logic [EDGE_N-1:0][7:0]  built, filt;
	logic signed [13:0]      h_q, v_q, h_c, v_c;
	logic signed [14:0]      a_q;
	logic signed [12:0]      b_q, c_q;
	logic [2:0]              y_q;
	logic                    bad;
	logic                    load_out;
	logic [63:0]             row;
	logic                    out_valid_q;
	logic [71:0]             out_data_q;
	logic                    out_last_q, out_bad_q;

	assign bad = (head.mode > MODE_PLANE) ||
		(head.chroma && (head.mode == MODE_DDL || head.mode == MODE_DDR));
	assign load_out = (state_q == ST_ROWS) && (!out_valid_q || m_tready);
	assign qout.pop   = load_out && (y_q == 3'd7);
	assign qout.valid = head_valid;

	// extended edge from the snapshot, then [1,2,1] smoothing
	always_comb begin
		logic [9:0] s;
		logic [7:0] lo;
		int first, last;
		built = edge_q;
		if (head.hl) begin
			for (int j = 0; j < 16; j++)
				built[16-j] = (j < 8 || head.hdl) ? head.nb[17+j] : head.nb[24];
			built[EDGE_MID] = head.nb[17];
			built[0] = built[1];
		end
		if (head.ht) begin
			for (int j = 0; j < 16; j++)
				built[18+j] = (j < 8 || head.htr) ? head.nb[1+j] : head.nb[8];
			built[EDGE_MID] = head.nb[1];
			built[34] = built[33];
		end
		if (head.htl) built[EDGE_MID] = head.nb[0];
		first = head.chroma ? 9 : 1;
		last  = head.chroma ? 25 : 33;
		filt = built;
		for (int p = 1; p < 34; p++) begin
			lo = (p == first) ? built[p] : built[p-1];
			s  = 10'(lo) + {1'b0, built[p], 1'b0} + 10'(built[p+1]) + 10'd2;
			if (p >= first && p <= last) filt[p] = s[9:2];
		end
	end

	function automatic logic signed [13:0] grad(input pix_t p4, p2, p5, p1, p6, p0,
			p7, pm);
		logic signed [13:0] r;
		r = 14'(($signed({1'b0, p4}) - $signed({1'b0, p2})))
			+ 14'sd2 * 14'($signed({1'b0, p5}) - $signed({1'b0, p1}))
			+ 14'sd3 * 14'($signed({1'b0, p6}) - $signed({1'b0, p0}))
			+ 14'sd4 * 14'($signed({1'b0, p7}) - $signed({1'b0, pm}));
		return r;
	endfunction

	assign h_c = grad(head.nb[5], head.nb[3], head.nb[6], head.nb[2],
		head.nb[7], head.nb[1], head.nb[8], head.nb[0]);
	assign v_c = grad(head.nb[21], head.nb[19], head.nb[22], head.nb[18],
		head.nb[23], head.nb[17], head.nb[24], head.nb[0]);

	// one row of pixels for row y_q
	always_comb begin
		logic signed [20:0] base, s;
		logic signed [15:0] sh;
		logic [5:0] pa, pb;
		logic [8:0] sum;
		pix_t p;
		base = 21'(a_q) + 21'($signed({1'b0, y_q}) - 4'sd3) * 21'(c_q) + 21'sd16;
		row = '0;
		for (int x = 0; x < 8; x++) begin
			s  = base + 21'(x - 3) * 21'(b_q);
			sh = 16'(s >>> 5);
			pa = 6'd0;
			pb = 6'd0;
			sum = 9'd0;
			p = PIX_MID;
			if (!bad) begin
				unique case (head.mode)
					MODE_V: p = head.nb[1+x];
					MODE_H: p = head.nb[17 + 32'(y_q)];
					MODE_DC: begin
						pa = 6'(16 - 32'(y_q));
						pb = 6'(18 + x);
						sum = 9'(edge_q[pa]) + 9'(edge_q[pb]);
						p = sum[8:1];
					end
					MODE_DDL: begin
						pa = 6'(19 + x + 32'(y_q));
						pb = 6'(15 - x - 32'(y_q));
						sum = 9'(edge_q[pa]) + 9'(edge_q[pb]);
						p = sum[8:1];
					end
					MODE_DDR: begin
						pa = 6'(17 + x - 32'(y_q));
						p = edge_q[pa];
					end
					MODE_DCL: begin
						pa = 6'(16 - 32'(y_q));
						p = edge_q[pa];
					end
					MODE_DCT: begin
						pb = 6'(18 + x);
						p = edge_q[pb];
					end
					MODE_FLAT: p = PIX_MID;
					default: begin
						if (sh < 0) p = 8'd0;
						else if (sh > 16'sd255) p = 8'd255;
						else p = sh[7:0];
					end
				endcase
			end
			row[8*x +: 8] = p;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE) begin
			edge_q <= filt;
			h_q    <= h_c;
			v_q    <= v_c;
		end
		if (state_q == ST_PLANE) begin
			a_q <= 15'(({7'd0, head.nb[24]} + {7'd0, head.nb[8]}) << 4);
			b_q <= 13'((18'(h_q) * 18'sd17 + 18'sd16) >>> 5);
			c_q <= 13'((18'(v_q) * 18'sd17 + 18'sd16) >>> 5);
		end
		if (load_out) begin
			out_data_q <= {5'd0, row, y_q};
			out_last_q <= (y_q == 3'd7);
			out_bad_q  <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			y_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (head_valid) state_q <= ST_EDGE;
				ST_EDGE:  state_q <= ST_PLANE;
				ST_PLANE: begin
					state_q <= ST_ROWS;
					y_q <= 3'd0;
				end
				default: begin
					if (load_out) begin
						y_q <= y_q + 3'd1;
						if (y_q == 3'd7) state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

endmodule

// ===== hdl/ip8_check.sv =====
// port-level checks for the intra 8x8 predictor, bound to the top level
// depends on intra_8x8_predictor_core ports only
module ip8_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'd7)))
		else $error("last flag off row seven");

	a_bad_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[66:3] == 64'h8080808080808080))
		else $error("bad mode row not flat");

	a_row_next: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(!m_tvalid || (3'(m_tdata[2:0] - $past(m_tdata[2:0])) == 3'd1)))
		else $error("row index skipped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled word changed");

endmodule

bind intra_8x8_predictor_core ip8_check u_ip8_check (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

// ===== tb/intra_8x8_predictor_core_tb.sv =====
// self-checking testbench for intra_8x8_predictor_core: loads neighbors, predicts blocks
// and compares every row word against an in-bench model of the edge filter and modes
// depends on ip8_pkg and the core rtl
module intra_8x8_predictor_core_tb;
	import ip8_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  row;
		logic [63:0] pix;
		logic        last;
		logic        bad;
	} row_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // sample_index, sample_value, mode, is_chroma, have_left,
	                        // have_top, have_topleft, have_topright, have_downleft
	logic        s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // row_index, row_pixels, zero pad
	logic        m_tuser;   // bad_mode
	logic        m_tlast;

	intra_8x8_predictor_core dut (.*);

	row_word_t   rows_due[$];
	pix_t        nb_pix[NB_N];
	pix_t        edge_pix[EDGE_N];
	int          errors = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// handshake signals settle between edges, so sample them at the falling edge
	logic        out_fire;
	logic [71:0] out_data;
	logic        out_bad, out_last;
	always @(negedge clk) begin
		out_fire = m_tvalid && m_tready && arst_n;
		out_data = m_tdata;
		out_bad  = m_tuser;
		out_last = m_tlast;
	end

	always @(posedge clk) begin
		row_word_t want;
		if (out_fire) begin
			if (rows_due.size() == 0) begin
				$error("unexpected row word %h", out_data);
				errors++;
			end else begin
				want = rows_due.pop_front();
				if (out_data[2:0] !== want.row) begin
					$error("row_index expected %0d actual %0d", want.row, out_data[2:0]);
					errors++;
				end
				if (out_data[66:3] !== want.pix) begin
					$error("row_pixels expected %h actual %h", want.pix, out_data[66:3]);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("last_row expected %0b actual %0b", want.last, out_last);
					errors++;
				end
				if (out_bad !== want.bad) begin
					$error("bad_mode expected %0b actual %0b", want.bad, out_bad);
					errors++;
				end
			end
		end
	end

	function automatic int eg(int i);
		return edge_pix[i + EDGE_MID];
	endfunction

	function automatic int top_raw(int k);
		return k < 0 ? nb_pix[0] : nb_pix[1 + k];
	endfunction

	function automatic int left_raw(int k);
		return k < 0 ? nb_pix[0] : nb_pix[17 + k];
	endfunction

	task automatic predict_block(logic [23:0] d);
		logic [3:0] mode;
		logic       chroma, hl, ht, htl, htr, hdl, bad;
		pix_t       old[EDGE_N];
		int         n, prev, h, v, a, b, c, p;
		row_word_t  w;
		mode = d[17:14]; chroma = d[18]; hl = d[19]; ht = d[20];
		htl = d[21]; htr = d[22]; hdl = d[23];
		if (hl) begin
			for (int j = 0; j < 16; j++)
				edge_pix[EDGE_MID - 1 - j] = (j < 8 || hdl) ? nb_pix[17 + j] : nb_pix[24];
			edge_pix[EDGE_MID] = nb_pix[17];
			edge_pix[0] = edge_pix[1];
		end
		if (ht) begin
			for (int j = 0; j < 16; j++)
				edge_pix[EDGE_MID + 1 + j] = (j < 8 || htr) ? nb_pix[1 + j] : nb_pix[8];
			edge_pix[EDGE_MID] = nb_pix[1];
			edge_pix[EDGE_N - 1] = edge_pix[EDGE_N - 2];
		end
		if (htl)
			edge_pix[EDGE_MID] = nb_pix[0];
		old = edge_pix;
		n = chroma ? 8 : 16;
		for (int i = -n; i <= n; i++) begin
			prev = old[EDGE_MID + ((i == -n) ? i : i - 1)];
			edge_pix[EDGE_MID + i] = 8'((prev + 2 * old[EDGE_MID + i]
				+ old[EDGE_MID + i + 1] + 2) >> 2);
		end
		bad = mode > MODE_PLANE || (chroma && (mode == MODE_DDL || mode == MODE_DDR));
		h = 0; v = 0;
		for (int i = 0; i < 4; i++) begin
			h += (i + 1) * (top_raw(4 + i) - top_raw(2 - i));
			v += (i + 1) * (left_raw(4 + i) - left_raw(2 - i));
		end
		a = 16 * (left_raw(7) + top_raw(7));
		b = (17 * h + 16) >>> 5;
		c = (17 * v + 16) >>> 5;
		for (int y = 0; y < 8; y++) begin
			w.row = 3'(y); w.last = (y == 7); w.bad = bad; w.pix = '0;
			for (int x = 0; x < 8; x++) begin
				if (bad) p = PIX_MID;
				else case (mode)
					MODE_V:    p = top_raw(x);
					MODE_H:    p = left_raw(y);
					MODE_DC:   p = (eg(-1 - y) + eg(1 + x)) >> 1;
					MODE_DDL:  p = (eg(2 + x + y) + eg(-2 - x - y)) >> 1;
					MODE_DDR:  p = eg(x - y);
					MODE_DCL:  p = eg(-1 - y);
					MODE_DCT:  p = eg(1 + x);
					MODE_FLAT: p = PIX_MID;
					default: begin
						p = (a + (x - 3) * b + (y - 3) * c + 16) >>> 5;
						p = p < 0 ? 0 : (p > 255 ? 255 : p);
					end
				endcase
				w.pix[8 * x +: 8] = 8'(p);
			end
			rows_due.push_back(w);
		end
	endtask

	task automatic send_word(logic cmd, logic [23:0] d);
		logic ok;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		if (cmd == CMD_PREDICT) predict_block(d);
		else if (d[5:0] < NB_N) nb_pix[d[5:0]] = d[13:6];
	endtask

	task automatic load_pix(int idx, int val);
		send_word(CMD_LOAD, {10'd0, 8'(val), 6'(idx)});
	endtask

	task automatic predict(logic [3:0] mode, logic [5:0] flags);
		send_word(CMD_PREDICT, {flags, mode, 8'($urandom), 6'($urandom)});
	endtask

	task automatic test_directed();
		for (int i = 0; i < NB_N; i++) load_pix(i, (i * 37 + 11) & 8'hff);
		// first predict writes the whole edge store so later partial flags read defined data
		predict(MODE_DC, 6'b111110);
		load_pix(3, 8'hff);
		load_pix(20, 8'h00);
		load_pix(63, 8'hff);            // out of range, ignored
		load_pix(33, 8'h55);
		for (int m = 0; m <= 8; m++) predict(4'(m), 6'b111110);
		predict(MODE_DDL, 6'b000000);   // no neighbors: edge from last time, smoothed again
		predict(MODE_DDR, 6'b100001);   // diagonal on chroma is rejected
		predict(MODE_DDL, 6'b010001);
		predict(4'd15, 6'b001100);
		predict(MODE_PLANE, 6'b001000); // corner only
		predict(MODE_DC, 6'b101110);    // padded top-right
		predict(MODE_DC, 6'b011110);    // padded down-left
	endtask

	task automatic test_random(int items, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (items) begin
			if ($urandom_range(99) < 60) begin
				case ($urandom_range(3))
					0: load_pix($urandom_range(32), 0);
					1: load_pix($urandom_range(32), 255);
					2: load_pix($urandom_range(63), $urandom_range(255));
					default: load_pix($urandom_range(32), $urandom_range(255));
				endcase
			end else begin
				predict(($urandom_range(9) == 0) ? 4'($urandom_range(15))
					: 4'($urandom_range(8)), 6'($urandom));
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (rows_due.size() != 0) @(posedge clk);
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = 1'b0;
		s_tdata  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(50, 0, 0);
		test_random(55, 52, 0);
		test_random(55, 0, 52);
		test_random(55, 15, 15);
		repeat (30) @(posedge clk);
		if (errors == 0 && rows_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ip8_pkg.sv
hdl/ip8_front.sv
hdl/ip8_back.sv
hdl/intra_8x8_predictor_core.sv
hdl/ip8_check.sv
tb/intra_8x8_predictor_core_tb.sv
